/* hdl/task_scheduler_rr_priority_aging_top_macros.svh */
// Assertion macros for the task scheduler top level.
`ifndef TASK_SCHEDULER_RR_PRIORITY_AGING_TOP_MACROS_SVH
`define TASK_SCHEDULER_RR_PRIORITY_AGING_TOP_MACROS_SVH

// same-cycle implication under reset
`define TSRPA_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication under reset
`define TSRPA_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/tsrpa_pkg.sv */
// Package: types and constants of the task scheduler.
`timescale 1ns / 1ps
package tsrpa_pkg;

	localparam int SLOT_COUNT_DEF = 64;

	localparam logic [2:0] ST_FREE     = 3'd0;
	localparam logic [2:0] ST_DYING    = 3'd1;
	localparam logic [2:0] ST_RUNNABLE = 3'd2;
	localparam logic [2:0] ST_RUNNING  = 3'd3;

	localparam logic [3:0] PRIO_TOP   = 4'd10;
	localparam logic [3:0] PRIO_LOW   = 4'd1;
	localparam logic [3:0] PRIO_RESET = 4'd5;

	localparam logic [1:0] MODE_RR   = 2'd0;
	localparam logic [1:0] MODE_PRIO = 2'd1;

	localparam logic [1:0] DEC_RUN     = 2'd0;
	localparam logic [1:0] DEC_RERUN   = 2'd1;
	localparam logic [1:0] DEC_HALT    = 2'd2;
	localparam logic [1:0] DEC_NO_LIVE = 2'd3;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_YIELD = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [5:0] slot_index;
		logic [2:0] slot_status;
		logic [3:0] slot_priority;
		logic       current_valid;
		logic [5:0] current_index;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  decision;
		logic [5:0]  chosen_index;
		logic [31:0] chosen_runs;
		logic [31:0] yield_total;
	} out_item_t;

	// classified item held in the queue
	typedef struct packed {
		logic       is_yield;
		logic       wr_ok;
		logic [5:0] slot_index;
		logic [2:0] slot_status;
		logic [3:0] slot_priority;
		logic       cur_ok;
		logic [5:0] current_index;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_head_t;

	typedef enum logic [2:0] {
		BS_CLEAR,
		BS_IDLE,
		BS_SCAN,
		BS_DECIDE,
		BS_AGE,
		BS_RUNRD,
		BS_RUNWR,
		BS_EMIT
	} back_state_t;

endpackage

/* hdl/tsrpa_front.sv */
// Front end: accepts items, classifies them and queues them.
`timescale 1ns / 1ps
module tsrpa_front import tsrpa_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_item,
	input  logic     q_pop,
	output q_head_t  q_head
);

	logic [1:0] count_q;
	logic       wptr_q;
	logic       rptr_q;
	q_entry_t   mem_q [2];
	q_entry_t   ent;
	logic       push;

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;

	always_comb begin
		ent.is_yield      = (in_item.operation == OP_YIELD);
		ent.wr_ok         = (int'(in_item.slot_index) < SLOT_COUNT);
		ent.slot_index    = in_item.slot_index;
		ent.slot_status   = in_item.slot_status;
		ent.slot_priority = in_item.slot_priority;
		ent.cur_ok        = in_item.current_valid && (int'(in_item.current_index) < SLOT_COUNT);
		ent.current_index = in_item.current_index;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
		end else begin
			if (push)
				wptr_q <= ~wptr_q;
			if (q_pop)
				rptr_q <= ~rptr_q;
			if (push && !q_pop)
				count_q <= count_q + 2'd1;
			else if (!push && q_pop)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= ent;
	end

	assign q_head.valid = (count_q != 2'd0);
	assign q_head.entry = mem_q[rptr_q];

endmodule

/* hdl/tsrpa_back.sv */
// Back end: slot tables, scan sequencer and result register.
`timescale 1ns / 1ps
module tsrpa_back import tsrpa_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] sched_mode,
	input  q_head_t    q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_item
);

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW = IW + 1;
	localparam logic [CW-1:0] CNT_END = CW'(SLOT_COUNT);

	back_state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic          rd_vld_q;
	logic [IW-1:0] rd_idx_q;
	logic [2:0]    stat_rd_q;
	logic [3:0]    prio_rd_q;
	logic [31:0]   runs_rd_q;
	logic [IW-1:0] last_q;
	logic [31:0]   yield_q;
	logic          cvalid_q;
	logic [IW-1:0] cidx_q;
	logic          live_q;
	logic          fa_found_q, f0_found_q, b_found_q;
	logic [IW-1:0] fa_q, f0_q, bidx_q;
	logic [3:0]    best_q;
	logic [2:0]    cstat_q;
	logic [IW-1:0] tgt_q;
	logic          inc_q;
	logic [1:0]    dec_q;
	logic [31:0]   runs_q;
	logic          out_valid_q;
	out_item_t     out_q;

	logic [2:0]    stat_mem [SLOT_COUNT];
	logic [3:0]    prio_mem [SLOT_COUNT];
	logic [31:0]   runs_mem [SLOT_COUNT];

	logic          stat_we, prio_we, runs_we;
	logic [IW-1:0] stat_wa, prio_wa;
	logic [2:0]    stat_wd;
	logic [3:0]    prio_wd;
	logic [31:0]   runs_wd;
	logic [IW-1:0] runs_wa;

	logic          scan_done, out_free, cnt_run, runnable;
	logic          nd_inc;
	logic [1:0]    nd_dec;
	logic [IW-1:0] nd_tgt;
	logic [1:0]    nd_halt;

	assign cnt_run   = (cnt_q != CNT_END);
	assign scan_done = !cnt_run && !rd_vld_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign runnable  = (stat_rd_q == ST_RUNNABLE);
	assign nd_halt   = live_q ? DEC_HALT : DEC_NO_LIVE;

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		nd_tgt  = '0;
		nd_inc  = 1'b0;
		nd_dec  = nd_halt;
		case (state_q)
			BS_CLEAR: begin
				if (!cnt_run)
					state_d = BS_IDLE;
			end
			BS_IDLE: begin
				if (q_head.valid) begin
					q_pop = 1'b1;
					if (q_head.entry.is_yield)
						state_d = BS_SCAN;
				end
			end
			BS_SCAN: begin
				if (scan_done)
					state_d = BS_DECIDE;
			end
			BS_DECIDE: begin
				state_d = BS_EMIT;
				if (sched_mode == MODE_RR || sched_mode == MODE_PRIO) begin
					if ((sched_mode == MODE_RR) ? (fa_found_q || f0_found_q) : b_found_q) begin
						nd_tgt  = (sched_mode == MODE_PRIO) ? bidx_q : (fa_found_q ? fa_q : f0_q);
						nd_inc  = 1'b1;
						nd_dec  = DEC_RUN;
						state_d = (sched_mode == MODE_PRIO) ? BS_AGE : BS_RUNRD;
					end else if (cvalid_q && cstat_q == ST_RUNNING) begin
						nd_tgt  = cidx_q;
						nd_inc  = 1'b1;
						nd_dec  = DEC_RERUN;
						state_d = BS_RUNRD;
					end
				end else if (cvalid_q) begin
					nd_tgt  = cidx_q;
					nd_dec  = DEC_RERUN;
					state_d = BS_RUNRD;
				end
			end
			BS_AGE: begin
				if (scan_done)
					state_d = BS_RUNRD;
			end
			BS_RUNRD: state_d = BS_RUNWR;
			BS_RUNWR: state_d = BS_EMIT;
			BS_EMIT: begin
				if (out_free)
					state_d = BS_IDLE;
			end
			default: state_d = BS_IDLE;
		endcase
	end

	always_comb begin
		stat_we = 1'b0;
		prio_we = 1'b0;
		runs_we = 1'b0;
		stat_wa = cnt_q[IW-1:0];
		prio_wa = cnt_q[IW-1:0];
		runs_wa = cnt_q[IW-1:0];
		stat_wd = ST_FREE;
		prio_wd = PRIO_RESET;
		runs_wd = '0;
		if (state_q == BS_CLEAR && cnt_run) begin
			stat_we = 1'b1;
			prio_we = 1'b1;
			runs_we = 1'b1;
		end else if (q_pop && !q_head.entry.is_yield && q_head.entry.wr_ok) begin
			stat_we = 1'b1;
			prio_we = 1'b1;
			stat_wa = IW'(q_head.entry.slot_index);
			prio_wa = IW'(q_head.entry.slot_index);
			stat_wd = q_head.entry.slot_status;
			prio_wd = q_head.entry.slot_priority;
		end else if (state_q == BS_AGE && rd_vld_q && runnable) begin
			prio_wa = rd_idx_q;
			if (rd_idx_q == tgt_q) begin
				prio_we = (prio_rd_q > PRIO_LOW);
				prio_wd = PRIO_LOW;
			end else begin
				prio_we = (prio_rd_q < PRIO_TOP);
				prio_wd = prio_rd_q + 4'd1;
			end
		end else if (state_q == BS_RUNWR && inc_q) begin
			runs_we = 1'b1;
			runs_wa = tgt_q;
			runs_wd = runs_rd_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (stat_we)
			stat_mem[stat_wa] <= stat_wd;
		if (prio_we)
			prio_mem[prio_wa] <= prio_wd;
		if (runs_we)
			runs_mem[runs_wa] <= runs_wd;
		stat_rd_q <= stat_mem[cnt_q[IW-1:0]];
		prio_rd_q <= prio_mem[cnt_q[IW-1:0]];
		runs_rd_q <= runs_mem[tgt_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BS_CLEAR;
			cnt_q       <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
			last_q      <= '0;
			yield_q     <= '0;
		end else begin
			state_q  <= state_d;
			rd_vld_q <= (state_q == BS_SCAN || state_q == BS_AGE) && cnt_run;
			case (state_q)
				BS_CLEAR, BS_SCAN, BS_AGE: begin
					if (cnt_run)
						cnt_q <= cnt_q + CW'(1);
				end
				default: cnt_q <= '0;
			endcase
			if (q_pop && q_head.entry.is_yield) begin
				yield_q <= yield_q + 32'd1;
				if (q_head.entry.cur_ok)
					last_q <= IW'(q_head.entry.current_index);
			end
			if (state_q == BS_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cvalid_q   <= q_head.entry.cur_ok;
			cidx_q     <= IW'(q_head.entry.current_index);
			live_q     <= 1'b0;
			fa_found_q <= 1'b0;
			f0_found_q <= 1'b0;
			b_found_q  <= 1'b0;
		end
		if (state_q == BS_SCAN && rd_vld_q) begin
			if (stat_rd_q == ST_RUNNABLE || stat_rd_q == ST_RUNNING || stat_rd_q == ST_DYING)
				live_q <= 1'b1;
			if (runnable && !fa_found_q && rd_idx_q > last_q) begin
				fa_found_q <= 1'b1;
				fa_q       <= rd_idx_q;
			end
			if (runnable && !f0_found_q) begin
				f0_found_q <= 1'b1;
				f0_q       <= rd_idx_q;
			end
			if (runnable && (!b_found_q || prio_rd_q > best_q)) begin
				b_found_q <= 1'b1;
				best_q    <= prio_rd_q;
				bidx_q    <= rd_idx_q;
			end
			if (rd_idx_q == cidx_q)
				cstat_q <= stat_rd_q;
		end
		rd_idx_q <= cnt_q[IW-1:0];
		if (state_q == BS_DECIDE) begin
			tgt_q  <= nd_tgt;
			inc_q  <= nd_inc;
			dec_q  <= nd_dec;
			runs_q <= '0;
		end
		if (state_q == BS_RUNWR)
			runs_q <= runs_rd_q + {31'd0, inc_q};
		if (state_q == BS_EMIT && out_free) begin
			out_q.decision     <= dec_q;
			out_q.chosen_index <= 6'(tgt_q);
			out_q.chosen_runs  <= runs_q;
			out_q.yield_total  <= yield_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

/* hdl/task_scheduler_rr_priority_aging_top.sv */
// A write item is queued when accepted, written to the slot tables when the back end takes
// it from the queue, and gives no result. A yield gives its result after a scan pass, in
// priority mode also after an aging pass: each pass reads the slot table one entry a cycle
// through one memory port. The back end takes no new item until that result is sent; a
// two-entry queue takes items meanwhile. Reset: asynchronous, active low; then a clearing
// pass over all slots takes no item from the queue. Mode register resets to round robin.
`timescale 1ns / 1ps
`include "task_scheduler_rr_priority_aging_top_macros.svh"
module task_scheduler_rr_priority_aging_top import tsrpa_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_data
);

	logic [1:0] mode_q;
	q_head_t    q_head;
	logic       q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= MODE_RR;
		else if (cfg_valid && cfg_ready)
			mode_q <= cfg_data;
	end

	tsrpa_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_pop    (q_pop),
		.q_head   (q_head)
	);

	tsrpa_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.sched_mode (mode_q),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

	`TSRPA_ASSERT_NOW(a_pop_needs_item, q_pop, q_head.valid, "pop from empty queue")
	`TSRPA_ASSERT_NOW(a_idle_no_slot, out_valid && (out_item.decision == DEC_HALT || out_item.decision == DEC_NO_LIVE), out_item.chosen_index == 6'd0 && out_item.chosen_runs == 32'd0, "halt result carries a slot")
	`TSRPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")

endmodule
